// File: sv/lkvc_pkg.sv
package lkvc_pkg;

    // Request type codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    // read_value returned on a get miss and on every set
    localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

    // Register map: capacity is the only register, at byte offset 0
    localparam int          APB_ADDR_W    = 2;
    localparam logic [1:0]  ADDR_CAPACITY = 2'd0;

    localparam int          CAP_W         = 5;
    localparam logic [4:0]  CAP_RESET     = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FINISH
    } state_t;

    // Control from the sequencer to the tag/recency array
    typedef struct packed {
        logic update;   // commit the lookup of the current transaction
        logic clear;    // drop every entry
        logic is_set;   // current transaction is a set
    } tag_ctl_t;

endpackage

// File: sv/lkvc_ifs.sv
interface lkvc_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] key;
    logic signed [31:0] value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// File: sv/lru_key_value_cache.sv
// Steps from request acceptance to the response being presented: accept,
//   tag compare and commit, value read-out into the output register.
// Acceptance: no new request is taken during the compare/commit step; the next
//   one may be accepted as the response loads; a stalled response holds it off.
// Reset: rst_n is asynchronous, active low; all entries invalid, capacity 16
//   (or MAX_ENTRIES if smaller). Writing capacity also drops every entry.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkvc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Request and response channels
    lkvc_req_if.sink                      req,
    lkvc_rsp_if.source                    rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [lkvc_pkg::CAP_W-1:0] CAP_INIT =
        (MAX_ENTRIES < 16) ? lkvc_pkg::CAP_W'(MAX_ENTRIES) : lkvc_pkg::CAP_RESET;

    // ------------------------------------------------------------------
    // Configuration: capacity register. A write clears the tag array.
    // ------------------------------------------------------------------
    logic [lkvc_pkg::CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0]           cap_eff;
    logic                       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == lkvc_pkg::ADDR_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_INIT;
        end
        else if (cfg_write)
        begin
            cap_reg <= pwdata[lkvc_pkg::CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == lkvc_pkg::ADDR_CAPACITY)
        begin
            prdata = 32'(cap_reg);
        end
    end

    // Zero behaves as one; anything above the array size is clamped to it.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (32'(cap_reg) > 32'(MAX_ENTRIES))
        begin
            cap_eff = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    //   IDLE   : waiting for a request
    //   LOOKUP : parallel key compare; keys, valid bits, ranks and the value
    //            memory write all commit at the end of this cycle. A get hit
    //            launches the value memory read here.
    //   FINISH : memory read data is back; load the response register. A new
    //            request may be accepted in the same cycle the response loads.
    // ------------------------------------------------------------------
    lkvc_pkg::state_t state_reg;
    lkvc_pkg::state_t state_next;

    logic        req_fire;
    logic        out_free;
    logic        load_out;
    logic        in_ready;

    // Captured request
    logic        req_set_reg;
    logic [31:0] key_reg;
    logic [31:0] value_reg;

    // Lookup outcome carried into FINISH
    logic        rsp_hit_reg;
    logic        rsp_get_reg;

    // Response register
    logic        out_valid_reg;
    logic        out_hit_reg;
    logic [31:0] out_data_reg;

    assign out_free = !out_valid_reg || rsp.ready;
    assign req_fire = req.valid && in_ready;
    assign req.ready = in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = lkvc_pkg::ST_LOOKUP;
                end
            end
            lkvc_pkg::ST_LOOKUP:
            begin
                state_next = lkvc_pkg::ST_FINISH;
            end
            lkvc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = req_fire ? lkvc_pkg::ST_LOOKUP : lkvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            lkvc_pkg::ST_LOOKUP:
            begin
                in_ready = 1'b0;
            end
            lkvc_pkg::ST_FINISH:
            begin
                in_ready = out_free;
                load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkvc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_set_reg <= (req.req_type == lkvc_pkg::REQ_SET);
            key_reg     <= req.key;
            value_reg   <= req.value;
        end
    end

    // ------------------------------------------------------------------
    // Tag / recency array and value memory
    // ------------------------------------------------------------------
    lkvc_pkg::tag_ctl_t tag_ctl;
    logic               hit;
    logic [IDX_W-1:0]   hit_slot;
    logic [IDX_W-1:0]   set_slot;
    logic               ram_we;
    logic               ram_re;
    logic [31:0]        ram_rdata;

    always_comb
    begin
        tag_ctl.update = (state_reg == lkvc_pkg::ST_LOOKUP);
        tag_ctl.clear  = cfg_write;
        tag_ctl.is_set = req_set_reg;
    end

    lkvc_tag_array #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_tags (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (tag_ctl),
        .key      (key_reg),
        .cap_eff  (cap_eff),
        .hit      (hit),
        .hit_slot (hit_slot),
        .set_slot (set_slot)
    );

    // A transaction either writes (set) or reads (get) the value memory,
    // never both, and the write lands before the next lookup, so no
    // forwarding path is needed.
    assign ram_we = (state_reg == lkvc_pkg::ST_LOOKUP) && req_set_reg;
    assign ram_re = (state_reg == lkvc_pkg::ST_LOOKUP) && !req_set_reg && hit;

    lkvc_value_ram #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_values (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_slot),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (hit_slot),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == lkvc_pkg::ST_LOOKUP)
        begin
            rsp_hit_reg <= hit;
            rsp_get_reg <= !req_set_reg;
        end
    end

    // ------------------------------------------------------------------
    // Response register; holds while the sink stalls.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_hit_reg  <= rsp_hit_reg;
            out_data_reg <= (rsp_get_reg && rsp_hit_reg) ? ram_rdata : lkvc_pkg::MISS_VALUE;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.read_value = out_data_reg;

`ifndef SYNTHESIS
    a_lookup_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lkvc_pkg::ST_LOOKUP |=> state_reg == lkvc_pkg::ST_FINISH)
        else $error("lookup did not advance to finish");

    a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == lkvc_pkg::ST_LOOKUP)
        else $error("accepted request did not start a lookup");

    a_miss_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.hit |-> rsp.read_value == lkvc_pkg::MISS_VALUE)
        else $error("miss response carries a stored value");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg) == lkvc_pkg::ST_FINISH)
        else $error("response raised outside finish");
`endif

endmodule

// File: sv/lkvc_value_ram.sv
module lkvc_value_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [31:0]       wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [31:0]       rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/lkvc_tag_array.sv
module lkvc_tag_array #(
    parameter int MAX_ENTRIES = 16,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lkvc_pkg::tag_ctl_t ctl,
    input  logic [31:0]        key,
    input  logic [CNT_W-1:0]   cap_eff,
    output logic               hit,
    output logic [IDX_W-1:0]   hit_slot,
    output logic [IDX_W-1:0]   set_slot
);

    // Ranks: 0 is most recent; valid ranks always form 0..count-1.
    logic [31:0]            keys_reg  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]       rank_reg  [MAX_ENTRIES];
    logic [IDX_W-1:0]       rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic [MAX_ENTRIES-1:0] match;
    logic [MAX_ENTRIES-1:0] oldest;
    logic [CNT_W-1:0]       count_m1;
    logic [IDX_W-1:0]       victim;
    logic [IDX_W-1:0]       hit_rank;
    logic                   has_room;
    logic                   commit;
    logic                   fill;
    logic                   key_write;

    assign count_m1 = count_reg - 1'b1;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match[i]  = valid_reg[i] && (keys_reg[i] == key);
            oldest[i] = valid_reg[i] && (rank_reg[i] == count_m1[IDX_W-1:0]);
        end
    end

    assign hit = |match;

    // Keys are unique, so either encoder direction gives the same slot.
    always_comb
    begin
        hit_slot = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_slot = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        victim = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (oldest[i])
            begin
                victim = IDX_W'(i);
            end
        end
    end

    assign hit_rank = rank_reg[hit_slot];
    assign has_room = count_reg < cap_eff;
    assign set_slot = hit ? hit_slot : (has_room ? count_reg[IDX_W-1:0] : victim);

    assign commit    = ctl.update && (hit || ctl.is_set);
    assign fill      = ctl.update && ctl.is_set && !hit && has_room;
    assign key_write = ctl.update && ctl.is_set && !hit;

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (commit)
            begin
                if (IDX_W'(i) == set_slot)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (!hit || (rank_reg[i] < hit_rank)))
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end
        if (fill)
        begin
            valid_next[set_slot] = 1'b1;
            count_next           = count_reg + 1'b1;
        end
        if (ctl.clear)
        begin
            valid_next = '0;
            count_next = '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_write)
        begin
            keys_reg[set_slot] <= key;
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// LRU key-value cache testbench.
// A driver and a monitor run as clocked blocks around the cache. The monitor
// keeps its own copy of the cache (keys, values, per-slot recency rank) and
// predicts hit/read_value for every accepted request. Each response is checked
// against the oldest prediction. Capacity is rewritten between phases while
// the cache is idle, and each write is read back over APB.
module testbench;

    localparam int SLOTS          = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASE_ITEMS    = 48;
    localparam int LONG_HOLD      = 48;

    typedef struct packed {
        logic        req_type;
        logic [31:0] key;
        logic [31:0] value;
    } cache_req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
    } cache_rsp_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lkvc_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    lkvc_req_if req_bus ();
    lkvc_rsp_if rsp_bus ();

    lru_key_value_cache #(
        .MAX_ENTRIES(SLOTS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .req    (req_bus),
        .rsp    (rsp_bus)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the cache contents
    // ------------------------------------------------------------------
    logic [31:0]    cached_key [SLOTS];
    logic [31:0]    cached_val [SLOTS];
    bit             slot_live  [SLOTS];
    int unsigned    lru_rank   [SLOTS];   // 0 = most recent
    int unsigned    live_count;
    logic [lkvc_pkg::CAP_W-1:0] capacity_reg;

    // Stimulus and scoreboard queues
    cache_req_t     request_q[$];         // pending requests, front = on the bus
    cache_rsp_t     expected_q[$];        // predicted responses, oldest first
    logic [31:0]    key_pool[$];          // keys reused within a phase to get hits

    // Handshake bookkeeping (set at posedge, read by the negedge drivers)
    logic           req_took;
    logic           rsp_took;
    int unsigned    rsp_count;
    int unsigned    fail_count;
    int unsigned    idle_cycles;

    // Idle knobs, changed per phase
    int unsigned    req_gap_max;
    int unsigned    rsp_gap_max;
    int unsigned    req_gap;
    int unsigned    rsp_wait;
    int unsigned    hold_left;

    function automatic void clear_cache_model();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            lru_rank[i]  = 0;
        end
        live_count = 0;
    endfunction

    // Age every live entry newer than limit, then make slot the newest.
    function automatic void touch_slot(int slot, int unsigned limit);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_live[i] && i != slot && lru_rank[i] < limit)
                lru_rank[i]++;
        end
        lru_rank[slot] = 0;
    endfunction

    // Apply one request to the shadow cache and return the response it should give.
    function automatic cache_rsp_t apply_request(cache_req_t r);
        int          found;
        int          slot;
        int unsigned cap;
        int unsigned oldest;
        cache_rsp_t  o;
        found = -1;
        slot  = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (found < 0 && slot_live[i] && cached_key[i] == r.key)
                found = i;
        end
        // zero capacity behaves as one, anything above the array as the array
        cap = 32'(capacity_reg);
        if (cap < 1)
            cap = 1;
        if (cap > SLOTS)
            cap = SLOTS;
        o.hit        = (found >= 0);
        o.read_value = lkvc_pkg::MISS_VALUE;
        if (found >= 0)
        begin
            if (r.req_type == lkvc_pkg::REQ_GET)
                o.read_value = cached_val[found];
            else
                cached_val[found] = r.value;
            touch_slot(found, lru_rank[found]);
        end
        else if (r.req_type == lkvc_pkg::REQ_SET)
        begin
            if (live_count < cap)
            begin
                // slots fill in order, so the next free one is live_count
                slot = live_count;
                live_count++;
                slot_live[slot] = 1'b1;
                lru_rank[slot]  = 0;
            end
            else
            begin
                // evict the live entry with the highest rank
                oldest = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_live[i] && lru_rank[i] >= oldest)
                    begin
                        oldest = lru_rank[i];
                        slot   = i;
                    end
                end
            end
            touch_slot(slot, 32'hFFFF_FFFF);
            cached_key[slot] = r.key;
            cached_val[slot] = r.value;
        end
        return o;
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic void queue_request(logic rt, logic [31:0] k, logic [31:0] v);
        cache_req_t r;
        r.req_type = rt;
        r.key      = k;
        r.value    = v;
        request_q.push_back(r);
    endfunction

    // Mostly keys from the phase pool so sets and gets meet; some fully random
    // keys and some extremes on top.
    function automatic void queue_random_request();
        int unsigned pick;
        logic [31:0] k;
        logic [31:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (pick < 90)
            k = $urandom;
        else
            k = extreme_word();
        v = ($urandom_range(0, 9) == 0) ? extreme_word() : 32'($urandom);
        queue_request($urandom_range(0, 1) ? lkvc_pkg::REQ_SET : lkvc_pkg::REQ_GET, k, v);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Everything the cache sees starts at a known value
    initial
    begin
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = lkvc_pkg::REQ_GET;
        req_bus.key      = '0;
        req_bus.value    = '0;
        rsp_bus.ready    = 1'b0;
    end

    // ------------------------------------------------------------------
    // Request driver: offers the front of request_q, waits a random gap
    // after each accepted transaction.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic nxt_valid;
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            req_gap = 0;
        end
        else
        begin
            nxt_valid = req_bus.valid;
            if (req_took)
            begin
                void'(request_q.pop_front());
                nxt_valid = 1'b0;
                req_gap   = $urandom_range(0, req_gap_max);
            end
            if (!nxt_valid && request_q.size() > 0)
            begin
                if (req_gap == 0)
                begin
                    nxt_valid         = 1'b1;
                    req_bus.req_type <= request_q[0].req_type;
                    req_bus.key      <= request_q[0].key;
                    req_bus.value    <= request_q[0].value;
                end
                else
                    req_gap--;
            end
            req_bus.valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Response sink: random ready gaps, plus two long hold-offs so the
    // cache backs up and stalls its request side.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            rsp_wait  = 0;
            hold_left = 0;
        end
        else
        begin
            if (rsp_took)
            begin
                rsp_wait = $urandom_range(0, rsp_gap_max);
                if (rsp_count == 90 || rsp_count == 300)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (rsp_wait > 0)
            begin
                rsp_wait--;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard: predicts on each request transaction and
    // checks each response transaction against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cache_req_t seen_req;
        cache_rsp_t want;
        if (!rst_n)
        begin
            req_took  <= 1'b0;
            rsp_took  <= 1'b0;
            rsp_count <= 0;
        end
        else
        begin
            req_took <= req_bus.valid && req_bus.ready;
            rsp_took <= rsp_bus.valid && rsp_bus.ready;
            // response first: a request taken this edge cannot be answered yet
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                rsp_count <= rsp_count + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected response hit=%0b read_value=%08h",
                             $time, rsp_bus.hit, rsp_bus.read_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp_bus.hit !== want.hit)
                    begin
                        $display("%0t: hit mismatch: expected %0b actual %0b",
                                 $time, want.hit, rsp_bus.hit);
                        fail_count++;
                    end
                    if (rsp_bus.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value mismatch: expected %08h actual %08h",
                                 $time, want.read_value, rsp_bus.read_value);
                        fail_count++;
                    end
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                seen_req.req_type = req_bus.req_type;
                seen_req.key      = req_bus.key;
                seen_req.value    = req_bus.value;
                expected_q.push_back(apply_request(seen_req));
            end
        end
    end

    // Watchdog: too long without any transaction or APB activity
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
            || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d responses outstanding",
                     $time, expected_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // APB: write capacity, then read it back
    // ------------------------------------------------------------------
    task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lkvc_pkg::ADDR_CAPACITY;
        pwdata  <= 32'(cap);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        capacity_reg = cap;
        clear_cache_model();
        // read-back transaction
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[lkvc_pkg::CAP_W-1:0] !== cap)
        begin
            $display("%0t: capacity read-back mismatch: expected %0d actual %0d",
                     $time, cap, prdata[lkvc_pkg::CAP_W-1:0]);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every request is taken and answered, then let the pipe settle.
    task automatic wait_idle();
        while (request_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [lkvc_pkg::CAP_W-1:0] phase_caps [9] = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd16,
                                                   5'd17, 5'd8, 5'd2, 5'd12};

    initial
    begin
        int unsigned pool_size;
        int unsigned eff_cap;
        fail_count   = 0;
        idle_cycles  = 0;
        req_gap_max  = 8;
        rsp_gap_max  = 8;
        capacity_reg = lkvc_pkg::CAP_RESET;
        clear_cache_model();

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset capacity: get on an empty store, extreme keys and
        // values, hits on each, an update, a plain miss.
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(lkvc_pkg::REQ_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_request(lkvc_pkg::REQ_SET, 32'h0000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(lkvc_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_SET, 32'h0000_0000, 32'hA5A5_A5A5);
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_GET, 32'h1234_5678, 32'h0000_0000);
        wait_idle();

        // Directed, capacity 2: eviction follows recency, not insertion order
        write_capacity(5'd2);
        queue_request(lkvc_pkg::REQ_SET, 32'h0000_0011, 32'h0000_0001);
        queue_request(lkvc_pkg::REQ_SET, 32'h0000_0022, 32'h0000_0002);
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0011, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_SET, 32'h0000_0033, 32'h0000_0003);   // evicts 0x22
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0022, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0011, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0033, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_SET, 32'h0000_0011, 32'h0000_0004);   // update in place
        queue_request(lkvc_pkg::REQ_SET, 32'h0000_0044, 32'h0000_0005);   // evicts 0x33
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0033, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0011, 32'h0000_0000);
        wait_idle();

        // Random phases, one per capacity setting, with the idle pattern
        // varied so some phases run back to back.
        for (int ph = 0; ph < 9; ph++)
        begin
            write_capacity(phase_caps[ph]);
            eff_cap = 32'(phase_caps[ph]);
            if (eff_cap < 1)
                eff_cap = 1;
            if (eff_cap > SLOTS)
                eff_cap = SLOTS;
            req_gap_max = (ph % 3 == 1) ? 0 : 8;
            rsp_gap_max = (ph % 2 == 1) ? 0 : 8;
            // a few more keys than slots, so both hits and evictions happen
            pool_size = eff_cap + 1 + $urandom_range(0, eff_cap / 2 + 1);
            key_pool.delete();
            for (int i = 0; i < pool_size; i++)
                key_pool.push_back(($urandom_range(0, 7) == 0) ? extreme_word()
                                                               : 32'($urandom));
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_random_request();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: lru_key_value_cache.f
sv/lkvc_pkg.sv
sv/lkvc_ifs.sv
sv/lkvc_value_ram.sv
sv/lkvc_tag_array.sv
sv/lru_key_value_cache.sv
tb/testbench.sv
